// File: rtl/core/ule_pkg.sv
// Package for the upload limit estimator: transfer payload types, controller
// command and status structs, the state enum, constants and the step table.
// No dependencies.
package ule_pkg;

  typedef struct packed {
    logic [7:0]  busy_slots;
    logic [7:0]  ready_slots;
    logic [7:0]  slot_list_size;
    logic [31:0] now_ms;
    logic [31:0] allowed_rate;
    logic [31:0] measured_rate;
  } ule_in_t;

  typedef struct packed {
    logic [31:0] effective_rate;
    logic [31:0] estimated_rate;
    logic [1:0]  adjust_event;
    logic [12:0] applied_delta;
  } ule_out_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SEED   = 2'd1,
    EV_REDUCE = 2'd2,
    EV_RAISE  = 2'd3
  } ule_event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEVEL,
    S_CHECK,
    S_STEP,
    S_APPLY,
    S_FINISH
  } ule_state_t;

  typedef struct packed {
    logic capture;
    logic level;
    logic check;
    logic step;
    logic apply;
    logic finish;
  } ule_cmd_t;

  typedef struct packed {
    logic out_ready;
  } ule_sts_t;

  typedef logic signed [8:0] level_t;

  localparam logic [31:0] RATE_UNLIMITED = 32'hFFFF_FFFF;
  localparam logic [31:0] WARMUP_MS      = 32'd60000;
  localparam logic [31:0] SEED_FALLBACK  = 32'd10240;
  localparam logic [31:0] RATE_FLOOR     = 32'd1024;
  localparam logic [31:0] HUNT_CHG_HI    = 32'd500;
  localparam logic [31:0] HUNT_CHG_LO    = 32'd300;
  localparam logic [31:0] HUNT_LOOP_LO   = 32'd1000;
  localparam logic [31:0] HUNT_LOOP_HI   = 32'd2000;
  localparam int          LEVEL_MAX      = 255;
  localparam int          LEVEL_TRIP     = 250;
  localparam int          LEVEL_LIFT     = 125;
  localparam int          LEVEL_SEED     = -200;
  localparam int          FRAC_HIGH      = 24;
  localparam int          FRAC_LOW       = 8;
  localparam logic [7:0]  BUSY_MIN       = 8'd2;
  localparam logic [7:0]  LIST_ARM       = 8'd3;
  localparam logic [3:0]  STEP_LAST      = 4'd11;

  function automatic logic [12:0] step_for(input logic [31:0] cnt);
    logic [3:0] idx;
    idx = ((|cnt[31:4]) || (cnt[3:0] > STEP_LAST)) ? STEP_LAST : cnt[3:0];
    unique case (idx)
      4'd0:    step_for = 13'd50;
      4'd1:    step_for = 13'd50;
      4'd2:    step_for = 13'd128;
      4'd3:    step_for = 13'd256;
      4'd4:    step_for = 13'd512;
      4'd5:    step_for = 13'd768;
      4'd6:    step_for = 13'd1024;
      4'd7:    step_for = 13'd1280;
      4'd8:    step_for = 13'd1536;
      4'd9:    step_for = 13'd2048;
      4'd10:   step_for = 13'd3072;
      default: step_for = 13'd4096;
    endcase
  endfunction

endpackage

// File: rtl/core/upload_limit_estimator_core.sv
// Upload limit estimator top level: joins the controller and the datapath.
// Depends on ule_pkg, ule_ctrl and ule_datapath.
// An input transfer is captured in S_IDLE and then passes S_LEVEL, S_CHECK, S_STEP,
// S_APPLY and S_FINISH before its result is registered; no new item is taken until the
// controller is back in S_IDLE, and an untaken result holds the sequence in its last step.
// Reset (rst_n low, synchronous) clears all estimator state and disables estimation.
module upload_limit_estimator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  ule_pkg::ule_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ule_pkg::ule_out_t out_data
);
  import ule_pkg::*;

  ule_cmd_t cmd;
  ule_sts_t sts;

  ule_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ule_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// File: rtl/core/ule_ctrl.sv
// Sequencing controller for the upload limit estimator.
// Depends on ule_pkg; drives the datapath through ule_cmd_t commands.
module ule_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ule_pkg::ule_sts_t sts,
  output ule_pkg::ule_cmd_t cmd
);
  import ule_pkg::*;

  ule_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd.level = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_capture_leads_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_LEVEL)
    else $error("capture not followed by level update");

  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH && !sts.out_ready |=> state_r == S_FINISH)
    else $error("result dropped while output register busy");

  a_no_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !cmd.capture)
    else $error("capture while an item is in progress");

endmodule

// File: rtl/core/ule_datapath.sv
// Datapath of the upload limit estimator: estimator state, busy level,
// warm-up timer, step counters, and the result register. Depends on ule_pkg.
module ule_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  ule_pkg::ule_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ule_pkg::ule_out_t out_data,
  input  ule_pkg::ule_cmd_t cmd,
  output ule_pkg::ule_sts_t sts
);
  import ule_pkg::*;

  logic        en_r;
  level_t      lvl_r;
  logic [31:0] warm_r, est_r, ups_r, downs_r, chg_r, loops_r;
  ule_in_t     in_r;
  ule_out_t    out_r;
  logic        out_valid_r;
  logic [31:0] deadline_r;
  logic [12:0] step_r, delta_r;
  ule_event_t  event_r;
  logic        go_r, hunt_r;

  logic [12:0] busy_x32, rdy_hi, rdy_lo;
  logic        frac_hi, frac_lo, busy_few, hunt;
  logic [31:0] seed_val, downs_nxt, ups_nxt, est_min, red_amt, raise_sat, raise_cap;
  logic [32:0] raise_sum;
  logic [12:0] red_floor;
  logic [31:0] eff_rate;

  // Busy fraction tests are done by cross-multiplication instead of dividing.
  always_comb begin
    busy_x32  = {in_r.busy_slots, 5'b0};
    rdy_hi    = 13'(in_r.ready_slots) * 13'(FRAC_HIGH + 1);
    rdy_lo    = 13'(in_r.ready_slots) * 13'(FRAC_LOW);
    busy_few  = in_r.busy_slots <= BUSY_MIN;
    frac_hi   = !busy_few && (busy_x32 >= rdy_hi);
    frac_lo   = busy_x32 < rdy_lo;
    hunt      = (chg_r > HUNT_CHG_HI) || ((chg_r > HUNT_CHG_LO) && (loops_r > HUNT_LOOP_LO)) ||
                (loops_r > HUNT_LOOP_HI);
    if (in_r.measured_rate != '0) begin
      seed_val = in_r.measured_rate;
    end else if (in_r.allowed_rate != '0 && in_r.allowed_rate != RATE_UNLIMITED) begin
      seed_val = in_r.allowed_rate;
    end else begin
      seed_val = SEED_FALLBACK;
    end
    downs_nxt = hunt_r ? '0 : downs_r + 32'd1;
    ups_nxt   = hunt_r ? '0 : ups_r + 32'd1;
    est_min   = 32'(step_r) + RATE_FLOOR;
    red_floor = (est_r > RATE_FLOOR) ? 13'(est_r - RATE_FLOOR) : '0;
    red_amt   = (est_r < est_min) ? 32'(red_floor) : 32'(step_r);
    raise_sum = {1'b0, est_r} + 33'(step_r);
    raise_sat = raise_sum[32] ? RATE_UNLIMITED : raise_sum[31:0];
    raise_cap = (raise_sat > in_r.allowed_rate) ? in_r.allowed_rate : raise_sat;
    eff_rate  = (go_r && in_r.allowed_rate > est_r) ? est_r : in_r.allowed_rate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      lvl_r       <= '0;
      warm_r      <= '0;
      est_r       <= '0;
      ups_r       <= '0;
      downs_r     <= '0;
      chg_r       <= '0;
      loops_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        en_r <= cfg_wr_data;
      end
      if (cmd.level && en_r) begin
        loops_r <= loops_r + 32'd1;
        if (in_r.ready_slots != '0) begin
          if (frac_hi && lvl_r < LEVEL_MAX) begin
            lvl_r <= lvl_r + level_t'(1);
            chg_r <= chg_r + 32'd1;
          end else if ((busy_few || frac_lo) && lvl_r > -LEVEL_MAX) begin
            lvl_r <= lvl_r - level_t'(1);
            chg_r <= chg_r + 32'd1;
          end
        end
      end
      if (cmd.check && en_r && warm_r == '0 && in_r.slot_list_size >= LIST_ARM) begin
        warm_r <= in_r.now_ms;
      end
      if (cmd.step) begin
        unique case (event_r)
          EV_SEED: begin
            est_r   <= seed_val;
            lvl_r   <= level_t'(LEVEL_SEED);
            chg_r   <= '0;
            loops_r <= '0;
          end
          EV_REDUCE: begin
            downs_r <= downs_nxt;
            ups_r   <= '0;
            lvl_r   <= '0;
            chg_r   <= '0;
            loops_r <= '0;
          end
          EV_RAISE: begin
            ups_r   <= ups_nxt;
            downs_r <= '0;
            lvl_r   <= '0;
            chg_r   <= '0;
            loops_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.apply) begin
        unique case (event_r)
          EV_REDUCE: est_r <= est_r - red_amt;
          EV_RAISE:  est_r <= raise_cap;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        if (en_r && in_r.ready_slots == in_r.busy_slots && in_r.slot_list_size != '0 &&
            lvl_r < LEVEL_LIFT) begin
          lvl_r <= level_t'(LEVEL_LIFT);
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r    <= in_data;
      go_r    <= 1'b0;
      event_r <= EV_NONE;
      delta_r <= '0;
    end
    if (cmd.level) begin
      deadline_r <= warm_r + WARMUP_MS;
    end
    if (cmd.check) begin
      hunt_r <= hunt;
      if (en_r && warm_r != '0 && in_r.now_ms >= deadline_r) begin
        go_r <= 1'b1;
        if (est_r == '0) begin
          if (lvl_r >= LEVEL_TRIP) begin
            event_r <= EV_SEED;
          end
        end else if (lvl_r > LEVEL_TRIP) begin
          event_r <= EV_REDUCE;
        end else if (lvl_r < -LEVEL_TRIP) begin
          event_r <= EV_RAISE;
        end
      end
    end
    if (cmd.step) begin
      if (event_r == EV_REDUCE) begin
        step_r <= step_for(downs_nxt);
      end else begin
        step_r <= step_for(ups_nxt);
      end
    end
    if (cmd.apply) begin
      unique case (event_r)
        EV_REDUCE: delta_r <= red_amt[12:0];
        EV_RAISE:  delta_r <= step_r;
        default: ;
      endcase
    end
    if (cmd.finish) begin
      out_r.effective_rate <= eff_rate;
      out_r.estimated_rate <= est_r;
      out_r.adjust_event   <= event_r;
      out_r.applied_delta  <= delta_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.out_ready = !out_valid_r || !out_stall;

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r >= -LEVEL_MAX)
    else $error("busy level below its range");

  a_quiet_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.adjust_event == EV_NONE || out_r.adjust_event == EV_SEED)
      |-> out_r.applied_delta == '0)
    else $error("nonzero delta without a rate change");

  a_counters_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_r.adjust_event != EV_NONE |-> chg_r == '0 && loops_r == '0)
    else $error("change or loop counter not cleared after an adjustment");

endmodule
